// ===== src/elrf_pkg.sv =====
// ---------------------------------------------------------------------------
// elrf_pkg
// shared types, sizes and codes of the event log ring with repeat filter
// ---------------------------------------------------------------------------
package elrf_pkg;

    localparam int RING_DEPTH       = 64;
    localparam int CHANNELS         = 16;
    localparam int PROTECTION_KINDS = 13;

    localparam int RING_AW   = $clog2(RING_DEPTH);
    localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int KIND_W    = $clog2(PROTECTION_KINDS);
    localparam int TBL_DEPTH = PROTECTION_KINDS * CHANNELS;
    localparam int TBL_AW    = $clog2(TBL_DEPTH);
    localparam int QDEPTH    = 2;
    localparam int QAW       = $clog2(QDEPTH);

    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    localparam logic [15:0] HOLD_RESET = 16'd2000;
    localparam logic [12:0] MASK_RESET = 13'd7167;
    localparam logic [15:0] CODE_RESET = 16'd0;

    // register word indexes (byte address / 4)
    localparam logic [1:0] REG_HOLD = 2'd0;
    localparam logic [1:0] REG_MASK = 2'd1;
    localparam logic [1:0] REG_CODE = 2'd2;

    typedef enum logic [1:0] {
        ACT_ADD   = 2'd0,
        ACT_QUERY = 2'd1,
        ACT_CLEAR = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    typedef struct packed {
        action_t             action;
        logic [31:0]         now_ms;
        logic [15:0]         main_type;
        logic [15:0]         sub_type;
        logic [31:0]         info;
        logic [31:0]         value_bits;
        logic [31:0]         after_time;
        logic [15:0]         max_count;
        logic                is_prot;
        logic                fault;
        logic [TBL_AW-1:0]   tbl_idx;
    } cmd_t;

    typedef struct packed {
        logic        fault_request;
        logic        stored;
        logic        record_valid;
        logic [31:0] rec_time;
        logic [15:0] rec_main;
        logic [15:0] rec_sub;
        logic [31:0] rec_info;
        logic [31:0] rec_value;
        logic [6:0]  returned_count;
        logic        last;
    } res_t;

    function automatic logic [RING_AW-1:0] ring_next(input logic [RING_AW-1:0] i);
        logic [RING_AW-1:0] n;
        begin
            if (i == RING_AW'(RING_DEPTH - 1))
                n = '0;
            else
                n = i + RING_AW'(1);
            return n;
        end
    endfunction

endpackage

// ===== src/elrf_front.sv =====
// ---------------------------------------------------------------------------
// elrf_front
// accepts input items and classifies protection events
// ---------------------------------------------------------------------------
module elrf_front (
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           action,
    input  logic [31:0]          now_ms,
    input  logic [15:0]          main_type,
    input  logic [15:0]          sub_type,
    input  logic [31:0]          info,
    input  logic [31:0]          value_bits,
    input  logic                 running,
    input  logic [31:0]          after_time,
    input  logic [15:0]          max_count,
    input  logic [12:0]          fault_enable_mask,
    input  logic [15:0]          protection_type_code,
    input  logic                 q_full,
    output logic                 q_push,
    output elrf_pkg::cmd_t       q_wdata
);

    logic                            kind_ok;
    logic                            chan_ok;
    logic                            is_prot;
    logic [elrf_pkg::KIND_W-1:0]     kind;
    logic [12:0]                     mask_sh;

    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full;

    assign kind_ok = (sub_type < 16'(elrf_pkg::PROTECTION_KINDS));
    assign chan_ok = (info < 32'(elrf_pkg::CHANNELS));
    assign is_prot = (main_type == protection_type_code) && kind_ok && chan_ok;
    assign kind    = sub_type[elrf_pkg::KIND_W-1:0];
    assign mask_sh = fault_enable_mask >> kind;

    always_comb
    begin
        q_wdata.action     = elrf_pkg::action_t'(action);
        q_wdata.now_ms     = now_ms;
        q_wdata.main_type  = main_type;
        q_wdata.sub_type   = sub_type;
        q_wdata.info       = info;
        q_wdata.value_bits = value_bits;
        q_wdata.after_time = after_time;
        q_wdata.max_count  = max_count;
        q_wdata.is_prot    = is_prot;
        q_wdata.fault      = is_prot && mask_sh[0] && running;
        // table row per subtype, one entry per channel
        q_wdata.tbl_idx    = elrf_pkg::TBL_AW'(32'(kind) * 32'(elrf_pkg::CHANNELS)
                             + 32'(info[elrf_pkg::CH_W-1:0]));
    end

endmodule

// ===== src/elrf_queue.sv =====
// ---------------------------------------------------------------------------
// elrf_queue
// short command queue between front and back
// ---------------------------------------------------------------------------
module elrf_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  elrf_pkg::cmd_t  wdata,
    output logic            full,
    input  logic            pop,
    output logic            not_empty,
    output elrf_pkg::cmd_t  rdata
);

    elrf_pkg::cmd_t                 slot_reg [elrf_pkg::QDEPTH];
    logic [elrf_pkg::QAW-1:0]       wr_ptr_reg;
    logic [elrf_pkg::QAW-1:0]       rd_ptr_reg;
    logic [elrf_pkg::QAW:0]         cnt_reg;

    assign full      = (cnt_reg == (elrf_pkg::QAW+1)'(elrf_pkg::QDEPTH));
    assign not_empty = (cnt_reg != '0);
    assign rdata     = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + elrf_pkg::QAW'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + elrf_pkg::QAW'(1);
            if (push && !pop)
                cnt_reg <= cnt_reg + (elrf_pkg::QAW+1)'(1);
            else if (pop && !push)
                cnt_reg <= cnt_reg - (elrf_pkg::QAW+1)'(1);
        end
    end

endmodule

// ===== src/elrf_back.sv =====
// ---------------------------------------------------------------------------
// elrf_back
// executes add, query and clear against the ring and the time table
// ---------------------------------------------------------------------------
module elrf_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_not_empty,
    input  elrf_pkg::cmd_t  q_rdata,
    output logic            q_pop,
    input  logic [15:0]     hold_time_ms,
    output logic            out_valid,
    input  logic            out_ready,
    output elrf_pkg::res_t  out_data
);

    typedef struct packed {
        logic [31:0] t;
        logic [15:0] mtype;
        logic [15:0] stype;
        logic [31:0] inf;
        logic [31:0] val;
    } rec_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD,
        ST_QRD,
        ST_QCHK,
        ST_QEND,
        ST_DONE
    } state_t;

    localparam int RAW = elrf_pkg::RING_AW;

    // memories
    rec_t        ring_mem [elrf_pkg::RING_DEPTH];
    logic [31:0] tbl_mem  [elrf_pkg::TBL_DEPTH];
    rec_t        ring_rdata_reg;
    logic [31:0] tbl_rdata_reg;

    logic        ring_we;
    logic        ring_re;
    rec_t        ring_wdata;
    logic        tbl_we;
    logic        tbl_re;

    state_t                           state_reg, state_next;
    elrf_pkg::cmd_t                   cmd_reg, cmd_next;
    logic [RAW-1:0]                   wr_idx_reg, wr_idx_next;
    logic [RAW-1:0]                   rd_idx_reg, rd_idx_next;
    logic [RAW-1:0]                   scan_reg, scan_next;
    logic [31:0]                      after_reg, after_next;
    logic [15:0]                      limit_reg, limit_next;
    logic [6:0]                       count_reg, count_next;
    logic                             pend_valid_reg, pend_valid_next;
    rec_t                             pend_reg, pend_next;
    logic [elrf_pkg::TBL_DEPTH-1:0]   tbl_vld_reg, tbl_vld_next;
    logic                             tbl_hit_reg, tbl_hit_next;
    logic                             out_valid_reg, out_valid_next;
    elrf_pkg::res_t                   out_reg, out_next;

    logic           can_emit;
    logic [31:0]    last_seen;
    logic [31:0]    gap;
    logic           keep;
    logic [6:0]     count_inc;
    logic [RAW-1:0] wr_adv;
    elrf_pkg::res_t empty_last;

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign can_emit  = !out_valid_reg || out_ready;

    assign last_seen = tbl_hit_reg ? tbl_rdata_reg : 32'd0;
    assign gap       = cmd_reg.now_ms - last_seen;
    assign keep      = !cmd_reg.is_prot || !(gap < {16'd0, hold_time_ms});
    assign count_inc = count_reg + 7'd1;
    assign wr_adv    = elrf_pkg::ring_next(wr_idx_reg);

    always_comb
    begin
        ring_wdata.t     = cmd_reg.now_ms;
        ring_wdata.mtype = cmd_reg.main_type;
        ring_wdata.stype = cmd_reg.sub_type;
        ring_wdata.inf   = cmd_reg.info;
        ring_wdata.val   = cmd_reg.value_bits;
    end

    always_comb
    begin
        empty_last      = '0;
        empty_last.last = 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (ring_we)
            ring_mem[wr_idx_reg] <= ring_wdata;
        if (ring_re)
            ring_rdata_reg <= ring_mem[scan_reg];
    end

    always_ff @(posedge clk)
    begin
        if (tbl_we)
            tbl_mem[cmd_reg.tbl_idx] <= cmd_reg.now_ms;
        if (tbl_re)
            tbl_rdata_reg <= tbl_mem[q_rdata.tbl_idx];
    end

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        wr_idx_next     = wr_idx_reg;
        rd_idx_next     = rd_idx_reg;
        scan_next       = scan_reg;
        after_next      = after_reg;
        limit_next      = limit_reg;
        count_next      = count_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        tbl_vld_next    = tbl_vld_reg;
        tbl_hit_next    = tbl_hit_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_next        = out_reg;
        q_pop           = 1'b0;
        ring_we         = 1'b0;
        ring_re         = 1'b0;
        tbl_we          = 1'b0;
        tbl_re          = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (q_not_empty)
                begin
                    q_pop    = 1'b1;
                    cmd_next = q_rdata;
                    case (q_rdata.action)
                        elrf_pkg::ACT_ADD:
                        begin
                            tbl_re       = 1'b1;
                            tbl_hit_next = tbl_vld_reg[q_rdata.tbl_idx];
                            state_next   = ST_ADD;
                        end
                        elrf_pkg::ACT_QUERY:
                        begin
                            scan_next       = rd_idx_reg;
                            after_next      = q_rdata.after_time;
                            limit_next      = (q_rdata.max_count == 16'd0) ? 16'd1
                                                                           : q_rdata.max_count;
                            count_next      = '0;
                            pend_valid_next = 1'b0;
                            state_next      = ST_QRD;
                        end
                        elrf_pkg::ACT_CLEAR:
                        begin
                            wr_idx_next  = '0;
                            rd_idx_next  = '0;
                            tbl_vld_next = '0;
                            state_next   = ST_DONE;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end

            ST_ADD:
            begin
                if (can_emit)
                begin
                    out_valid_next         = 1'b1;
                    out_next               = empty_last;
                    out_next.fault_request = cmd_reg.fault;
                    out_next.stored        = keep;
                    if (keep)
                    begin
                        ring_we     = 1'b1;
                        wr_idx_next = wr_adv;
                        // full ring drops its oldest record
                        if (wr_adv == rd_idx_reg)
                            rd_idx_next = elrf_pkg::ring_next(rd_idx_reg);
                        if (cmd_reg.is_prot)
                        begin
                            tbl_we                        = 1'b1;
                            tbl_vld_next[cmd_reg.tbl_idx] = 1'b1;
                        end
                    end
                    state_next = ST_IDLE;
                end
            end

            ST_QRD:
            begin
                if (scan_reg == wr_idx_reg)
                    state_next = ST_QEND;
                else
                begin
                    ring_re    = 1'b1;
                    state_next = ST_QCHK;
                end
            end

            ST_QCHK:
            begin
                if (ring_rdata_reg.t >= after_reg)
                begin
                    if (!pend_valid_reg || can_emit)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_valid_next          = 1'b1;
                            out_next                = '0;
                            out_next.record_valid   = 1'b1;
                            out_next.rec_time       = pend_reg.t;
                            out_next.rec_main       = pend_reg.mtype;
                            out_next.rec_sub        = pend_reg.stype;
                            out_next.rec_info       = pend_reg.inf;
                            out_next.rec_value      = pend_reg.val;
                            out_next.returned_count = count_reg;
                        end
                        pend_next       = ring_rdata_reg;
                        pend_valid_next = 1'b1;
                        count_next      = count_inc;
                        after_next      = ring_rdata_reg.t;
                        if ({9'd0, count_inc} >= limit_reg)
                            state_next = ST_QEND;
                        else
                        begin
                            scan_next  = elrf_pkg::ring_next(scan_reg);
                            state_next = ST_QRD;
                        end
                    end
                end
                else
                begin
                    scan_next  = elrf_pkg::ring_next(scan_reg);
                    state_next = ST_QRD;
                end
            end

            ST_QEND:
            begin
                if (can_emit)
                begin
                    out_valid_next = 1'b1;
                    out_next       = empty_last;
                    if (pend_valid_reg)
                    begin
                        out_next.record_valid   = 1'b1;
                        out_next.rec_time       = pend_reg.t;
                        out_next.rec_main       = pend_reg.mtype;
                        out_next.rec_sub        = pend_reg.stype;
                        out_next.rec_info       = pend_reg.inf;
                        out_next.rec_value      = pend_reg.val;
                        out_next.returned_count = count_reg;
                    end
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end

            ST_DONE:
            begin
                if (can_emit)
                begin
                    out_valid_next = 1'b1;
                    out_next       = empty_last;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            wr_idx_reg     <= '0;
            rd_idx_reg     <= '0;
            pend_valid_reg <= 1'b0;
            tbl_vld_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            wr_idx_reg     <= wr_idx_next;
            rd_idx_reg     <= rd_idx_next;
            pend_valid_reg <= pend_valid_next;
            tbl_vld_reg    <= tbl_vld_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        scan_reg    <= scan_next;
        after_reg   <= after_next;
        limit_reg   <= limit_next;
        count_reg   <= count_next;
        pend_reg    <= pend_next;
        tbl_hit_reg <= tbl_hit_next;
        out_reg     <= out_next;
    end

`ifndef SYNTHESIS
    a_store_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ADD && can_emit && keep) |=> (wr_idx_reg != rd_idx_reg))
        else $error("ring empty right after a stored add");

    a_pend_in_query: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> (state_reg == ST_QRD || state_reg == ST_QCHK
                            || state_reg == ST_QEND))
        else $error("pending record outside a query");

    a_record_counted: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.record_valid) |->
            (out_reg.returned_count != 7'd0 && !out_reg.stored))
        else $error("returned record without count");

    a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (state_reg == ST_IDLE && q_not_empty))
        else $error("queue popped while busy");
`endif

endmodule

// ===== src/event_log_ring_with_repeat_filter.sv =====
// ---------------------------------------------------------------------------
// event_log_ring_with_repeat_filter
// event log in an overwriting ring with a per-channel repeat filter
// ---------------------------------------------------------------------------
// usage:
//  - input channel (in_valid/in_ready) takes one item per action: add, query
//    or clear; output channel (out_valid/out_ready) returns result items
//  - add and clear give one result item, a query gives one per matching
//    record (up to max_count, 0 taken as 1) or one empty item if none match;
//    last marks the final result of each input item
//  - with an empty queue and an idle back end the first result is valid once
//    the item has passed the queue, the back end state and the output register
//  - an add passes the back end as pop with time table read, then ring and
//    table write with the result; a query reads, then checks, each ring
//    slot walked, set by the single registered read port of the record
//    memory, between the pop and the final result
//  - clear and unused actions pass the back end as pop, then the result
//  - items are carried out one at a time; the next one is popped the cycle
//    after the previous final result is registered
//  - a two-entry queue decouples acceptance from execution, so up to two
//    items are taken while the back end is busy or the output stalls
//  - a stalled receiver holds the back end; the output register keeps its
//    item unchanged until out_ready
//  - reset empties the ring and marks every time table entry as zero, with
//    no clearing pass; registers return to their reset values
//  - registers over the apb port: 0x0 hold time, 0x4 fault mask,
//    0x8 protection type code; write them only while the block is idle
// ---------------------------------------------------------------------------
module event_log_ring_with_repeat_filter (
    input  logic                           clk,
    input  logic                           rst_n,
    // configuration
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [elrf_pkg::PADDR_W-1:0]   paddr,
    input  logic [elrf_pkg::PDATA_W-1:0]   pwdata,
    output logic [elrf_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready,
    // input items
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [1:0]                     action,
    input  logic [31:0]                    now_ms,
    input  logic [15:0]                    main_type,
    input  logic [15:0]                    sub_type,
    input  logic [31:0]                    info,
    input  logic [31:0]                    value_bits,
    input  logic                           running,
    input  logic [31:0]                    after_time,
    input  logic [15:0]                    max_count,
    // result items
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           fault_request,
    output logic                           stored,
    output logic                           record_valid,
    output logic [31:0]                    rec_time,
    output logic [15:0]                    rec_main,
    output logic [15:0]                    rec_sub,
    output logic [31:0]                    rec_info,
    output logic [31:0]                    rec_value,
    output logic [6:0]                     returned_count,
    output logic                           last
);

    // configuration registers
    logic [15:0] hold_reg;
    logic [12:0] mask_reg;
    logic [15:0] code_reg;
    logic        cfg_wr;
    logic [1:0]  reg_sel;

    // front to queue to back
    logic            q_push;
    logic            q_full;
    logic            q_pop;
    logic            q_not_empty;
    elrf_pkg::cmd_t  q_wdata;
    elrf_pkg::cmd_t  q_rdata;
    elrf_pkg::res_t  res;

    assign pready  = 1'b1;
    assign reg_sel = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite;

    // register read mux, unused addresses read as zero
    always_comb
    begin
        case (reg_sel)
            elrf_pkg::REG_HOLD: prdata = {16'd0, hold_reg};
            elrf_pkg::REG_MASK: prdata = {19'd0, mask_reg};
            elrf_pkg::REG_CODE: prdata = {16'd0, code_reg};
            default:            prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_reg <= elrf_pkg::HOLD_RESET;
            mask_reg <= elrf_pkg::MASK_RESET;
            code_reg <= elrf_pkg::CODE_RESET;
        end
        else if (cfg_wr)
        begin
            case (reg_sel)
                elrf_pkg::REG_HOLD: hold_reg <= pwdata[15:0];
                elrf_pkg::REG_MASK: mask_reg <= pwdata[12:0];
                elrf_pkg::REG_CODE: code_reg <= pwdata[15:0];
                default:            ;
            endcase
        end
    end

    // front: accept and classify
    elrf_front u_front (
        .in_valid             (in_valid),
        .in_ready             (in_ready),
        .action               (action),
        .now_ms               (now_ms),
        .main_type            (main_type),
        .sub_type             (sub_type),
        .info                 (info),
        .value_bits           (value_bits),
        .running              (running),
        .after_time           (after_time),
        .max_count            (max_count),
        .fault_enable_mask    (mask_reg),
        .protection_type_code (code_reg),
        .q_full               (q_full),
        .q_push               (q_push),
        .q_wdata              (q_wdata)
    );

    // command queue
    elrf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .wdata     (q_wdata),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .rdata     (q_rdata)
    );

    // back: ring, time table and result register
    elrf_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_not_empty  (q_not_empty),
        .q_rdata      (q_rdata),
        .q_pop        (q_pop),
        .hold_time_ms (hold_reg),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_data     (res)
    );

    assign fault_request  = res.fault_request;
    assign stored         = res.stored;
    assign record_valid   = res.record_valid;
    assign rec_time       = res.rec_time;
    assign rec_main       = res.rec_main;
    assign rec_sub        = res.rec_sub;
    assign rec_info       = res.rec_info;
    assign rec_value      = res.rec_value;
    assign returned_count = res.returned_count;
    assign last           = res.last;

endmodule
